FILE: hdl/sba_pkg.sv
package sba_pkg;

    localparam int SIZE_W = 32;
    localparam int ALOG_W = 5;
    localparam int BUSY_W = 9;
    localparam int ID_W   = 4;
    localparam int OFF_W  = 21;
    localparam int CNT_W  = 4;
    // holds any aligned offset plus any aligned size
    localparam int SUM_W  = 34;

    typedef enum logic {
        S_IDLE,
        S_COMMIT
    } t_state;

    // shared control seen by every pool cell
    typedef struct packed {
        logic              search_en;
        logic              append;
        logic              upd;
        logic [ID_W-1:0]   app_id;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  fill;
        logic [BUSY_W-1:0] busy;
    } t_pool_ctl;

    // value passed from cell to cell along the row
    typedef struct packed {
        logic            found;
        logic            shift;
        logic [ID_W-1:0] id;
    } t_chain;

    // ids without a mask bit count as idle
    function automatic logic is_busy(input logic [ID_W-1:0] id,
                                     input logic [BUSY_W-1:0] mask);
        logic r;
        r = 1'b0;
        if (id < ID_W'(BUSY_W)) begin
            r = mask[id[ID_W-1:0]];
        end
        return r;
    endfunction

endpackage

FILE: hdl/sba_req_if.sv
interface sba_req_if;
    import sba_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [SIZE_W-1:0] request_bytes;
    logic [ALOG_W-1:0] align_log2;
    logic [BUSY_W-1:0] busy_mask;

    modport source (output valid, mode, request_bytes, align_log2, busy_mask, input ready);
    modport sink   (input valid, mode, request_bytes, align_log2, busy_mask, output ready);
endinterface

FILE: hdl/sba_rsp_if.sv
interface sba_rsp_if;
    import sba_pkg::*;

    logic             valid;
    logic             ready;
    logic [ID_W-1:0]  buffer_id;
    logic [OFF_W-1:0] range_offset;
    logic             dedicated;
    logic             created_new;
    logic             waited_oldest;

    modport source (output valid, buffer_id, range_offset, dedicated, created_new,
                    waited_oldest, input ready);
    modport sink   (input valid, buffer_id, range_offset, dedicated, created_new,
                    waited_oldest, output ready);
endinterface

FILE: hdl/sba_cfg_if.sv
interface sba_cfg_if;
    logic valid;
    logic ready;
    logic accel_no_reuse;

    modport source (output valid, accel_no_reuse, input ready);
    modport sink   (input valid, accel_no_reuse, output ready);
endinterface

FILE: hdl/sba_cell.sv
module sba_cell #(
    parameter int IDX = 0
) (
    input  logic                       i_clk,
    input  sba_pkg::t_pool_ctl         i_ctl,
    input  logic                       i_wait,
    input  logic [sba_pkg::ID_W-1:0]   i_next,
    output logic [sba_pkg::ID_W-1:0]   o_view,
    input  sba_pkg::t_chain            i_chain,
    output sba_pkg::t_chain            o_chain
);
    import sba_pkg::*;

    logic [ID_W-1:0] r_id;
    logic            w_in_pool;
    logic            w_idle;
    logic            w_take;

    // entry as it looks after the current buffer is appended
    assign o_view    = (i_ctl.append && i_ctl.count == CNT_W'(IDX)) ? i_ctl.app_id : r_id;
    assign w_in_pool = CNT_W'(IDX) < i_ctl.fill;
    assign w_idle    = w_in_pool && !is_busy(o_view, i_ctl.busy);
    assign w_take    = (i_ctl.search_en && !i_chain.found && w_idle)
                     || (i_wait && IDX == 0);

    always_comb begin
        o_chain.found = i_chain.found || (i_ctl.search_en && w_idle);
        o_chain.shift = i_chain.shift || w_take;
        o_chain.id    = w_take ? o_view : i_chain.id;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            r_id <= o_chain.shift ? i_next : o_view;
        end
    end
endmodule

FILE: hdl/staging_bump_allocator_with_pool.sv
// staging bump allocator: hands out byte ranges from fixed size staging
// buffers of BUFFER_BYTES bytes, named by 4-bit ids in order of creation.
// each request word gives mode (0 allocate, 1 trim), a size, an alignment
// exponent and a busy mask for ids 0 to 8; each accepted word yields exactly
// one result word with the buffer id, the offset inside it and the flags
// dedicated, created_new and waited_oldest. a request larger than a buffer
// only sets dedicated and leaves the state alone; trim drops every buffer.
// when a range does not fit, the current buffer joins the back of an
// oldest-first pool of up to MAX_POOL entries, held in a row of cells that
// each keep one id and shift toward the front when an entry is taken out.
// a word passes through the accept cycle (offset rewind and
// alignment) and the commit cycle (fit check, pool search along the cell
// row, state update); the commit waits while an older result sits in
// the result register on o_rsp.ready. the next request word is taken once
// the commit is done, so one result may still wait in the output register
// while the next word is worked on. the config word accel_no_reuse may be
// written any time the block is idle; it is always ready.
module staging_bump_allocator_with_pool #(
    parameter int BUFFER_BYTES = 1048576,
    parameter int MAX_POOL     = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sba_req_if.sink   i_req,
    sba_rsp_if.source o_rsp,
    sba_cfg_if.sink   i_cfg
);
    import sba_pkg::*;

    // fill offset holds up to BUFFER_BYTES + 1
    localparam int FW = $clog2(BUFFER_BYTES + 2);

    // control state
    t_state          r_state;
    t_state          n_state;
    logic            r_accel;
    logic            r_cur_valid;
    logic [ID_W-1:0] r_cur_id;
    logic [FW-1:0]   r_fill;
    logic [CNT_W-1:0] r_pool_cnt;
    logic [ID_W-1:0] r_created;
    logic            r_o_valid;

    // word captured at accept
    logic              r_trim;
    logic              r_ded;
    logic              r_new;
    logic [ID_W-1:0]   r_cid;
    logic [SUM_W-1:0]  r_off;
    logic [SUM_W-1:0]  r_asz;
    logic [SIZE_W-1:0] r_size;
    logic [BUSY_W-1:0] r_busy;

    // result word
    logic [ID_W-1:0]  r_o_id;
    logic [OFF_W-1:0] r_o_off;
    logic             r_o_ded;
    logic             r_o_new;
    logic             r_o_wait;

    logic w_accept;
    logic w_fire;

    // accept cycle
    logic [ID_W-1:0]  w_cur_eff;
    logic [SUM_W-1:0] w_off0;
    logic [SUM_W-1:0] w_mask;
    logic [SUM_W-1:0] w_off_al;
    logic [SUM_W-1:0] w_asz;
    logic             w_ded;

    // commit cycle
    logic [SUM_W-1:0] w_sum;
    logic             w_ovf;
    logic [ID_W-1:0]  w_cc1;
    logic [ID_W-1:0]  w_cc_fin;
    logic             w_full;
    logic             w_found;
    logic             w_wait;
    logic             w_mk_new;
    logic [ID_W-1:0]  w_id_fin;
    logic [CNT_W-1:0] w_pc_fin;
    logic [SUM_W-1:0] w_end_raw;
    logic [SUM_W-1:0] w_end;
    t_pool_ctl        w_ctl;

    logic [ID_W-1:0] w_view  [MAX_POOL+1];
    t_chain          w_chain [MAX_POOL+1];

    assign i_cfg.ready = 1'b1;

    // state machine: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state machine: outputs
    always_comb begin
        i_req.ready = 1'b0;
        w_fire      = 1'b0;
        case (r_state)
            S_IDLE:   i_req.ready = 1'b1;
            S_COMMIT: w_fire = !r_o_valid || o_rsp.ready;
            default:  i_req.ready = 1'b0;
        endcase
    end

    assign w_accept = i_req.valid && i_req.ready;

    // accept cycle: pick the buffer, rewind if it is idle and accel_no_reuse is off, align the offset
    assign w_cur_eff = r_cur_valid ? r_cur_id : r_created;
    assign w_off0    = (!is_busy(w_cur_eff, i_req.busy_mask) && !r_accel)
                     ? '0 : SUM_W'(r_fill);
    assign w_mask    = (SUM_W'(1) << i_req.align_log2) - SUM_W'(1);
    assign w_off_al  = (w_off0 + w_mask) & ~w_mask;
    // the offset is already aligned, so aligning the end equals offset + aligned size
    assign w_asz     = (SUM_W'(i_req.request_bytes) + w_mask) & ~w_mask;
    assign w_ded     = SUM_W'(i_req.request_bytes) > SUM_W'(BUFFER_BYTES);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_trim <= i_req.mode;
            r_ded  <= w_ded;
            r_new  <= !r_cur_valid;
            r_cid  <= w_cur_eff;
            r_off  <= w_off_al;
            r_asz  <= w_asz;
            r_size <= i_req.request_bytes;
            r_busy <= i_req.busy_mask;
        end
    end

    // commit cycle: does the range fit
    assign w_sum = r_off + SUM_W'(r_size);
    assign w_ovf = w_sum > SUM_W'(BUFFER_BYTES);
    assign w_cc1 = r_created + ID_W'(r_new);

    // pool control for the cell row
    always_comb begin
        w_ctl.search_en = w_ovf && !r_accel;
        w_ctl.append    = w_ovf && (r_pool_cnt < CNT_W'(MAX_POOL));
        w_ctl.upd       = w_fire && !r_trim && !r_ded && w_ovf;
        w_ctl.app_id    = r_cid;
        w_ctl.count     = r_pool_cnt;
        w_ctl.fill      = r_pool_cnt + CNT_W'(w_ctl.append);
        w_ctl.busy      = r_busy;
    end

    assign w_view[MAX_POOL] = '0;
    assign w_chain[0]       = '0;

    for (genvar g = 0; g < MAX_POOL; g++) begin : g_cell
        sba_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_wait  (w_wait),
            .i_next  (w_view[g+1]),
            .o_view  (w_view[g]),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1])
        );
    end

    // no idle pooled buffer: make a new one, or wait on the oldest when the pool is full
    assign w_found  = w_chain[MAX_POOL].found;
    assign w_full   = w_ctl.fill == CNT_W'(MAX_POOL);
    assign w_wait   = w_ovf && !w_found && w_full;
    assign w_mk_new = w_ovf && !w_found && !w_full;
    assign w_id_fin = !w_ovf ? r_cid
                    : (w_found || w_wait) ? w_chain[MAX_POOL].id : w_cc1;
    assign w_cc_fin = w_cc1 + ID_W'(w_mk_new);
    assign w_pc_fin = w_ctl.fill - CNT_W'(w_found || w_wait);

    // new fill offset, held at one past the end when it runs over
    assign w_end_raw = w_ovf ? r_asz : r_off + r_asz;
    assign w_end     = (w_end_raw > SUM_W'(BUFFER_BYTES)) ? SUM_W'(BUFFER_BYTES + 1) : w_end_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_accel     <= 1'b0;
            r_cur_valid <= 1'b0;
            r_cur_id    <= '0;
            r_fill      <= '0;
            r_pool_cnt  <= '0;
            r_created   <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_accel <= i_cfg.accel_no_reuse;
            end
            if (w_fire) begin
                r_o_valid <= 1'b1;
                if (r_trim) begin
                    r_cur_valid <= 1'b0;
                    r_cur_id    <= '0;
                    r_fill      <= '0;
                    r_pool_cnt  <= '0;
                    r_created   <= '0;
                end else if (!r_ded) begin
                    r_cur_valid <= 1'b1;
                    r_cur_id    <= w_id_fin;
                    r_fill      <= FW'(w_end);
                    r_pool_cnt  <= w_pc_fin;
                    r_created   <= w_cc_fin;
                end
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            if (r_trim || r_ded) begin
                r_o_id   <= '0;
                r_o_off  <= '0;
                r_o_ded  <= !r_trim;
                r_o_new  <= 1'b0;
                r_o_wait <= 1'b0;
            end else begin
                r_o_id   <= w_id_fin;
                r_o_off  <= w_ovf ? '0 : r_off[OFF_W-1:0];
                r_o_ded  <= 1'b0;
                r_o_new  <= w_ovf ? w_mk_new : r_new;
                r_o_wait <= w_wait;
            end
        end
    end

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.buffer_id     = r_o_id;
    assign o_rsp.range_offset  = r_o_off;
    assign o_rsp.dedicated     = r_o_ded;
    assign o_rsp.created_new   = r_o_new;
    assign o_rsp.waited_oldest = r_o_wait;
endmodule

FILE: hdl/sba_chk.sv
module sba_chk (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_req_valid,
    input logic                     i_req_ready,
    input logic                     i_rsp_valid,
    input logic                     i_rsp_ready,
    input logic [sba_pkg::ID_W-1:0] i_rsp_id,
    input logic [sba_pkg::OFF_W-1:0] i_rsp_off,
    input logic                     i_rsp_ded,
    input logic                     i_rsp_new,
    input logic                     i_rsp_wait
);
    import sba_pkg::*;

    // one word at a time: no back to back accept
    a_one_at_a_time: assert property (@(posedge i_clk)
        (i_rst_n && i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted in consecutive cycles");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    a_ded_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_ded) |->
            (i_rsp_id == '0 && i_rsp_off == '0 && !i_rsp_new && !i_rsp_wait))
        else $error("dedicated result carries a range");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_rsp_new && i_rsp_wait))
        else $error("new buffer and wait on oldest in one result");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_id) && $stable(i_rsp_off)
             && $stable(i_rsp_ded) && $stable(i_rsp_new) && $stable(i_rsp_wait)))
        else $error("stalled result word changed");
endmodule

bind staging_bump_allocator_with_pool sba_chk u_sba_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_id    (o_rsp.buffer_id),
    .i_rsp_off   (o_rsp.range_offset),
    .i_rsp_ded   (o_rsp.dedicated),
    .i_rsp_new   (o_rsp.created_new),
    .i_rsp_wait  (o_rsp.waited_oldest)
);
